[hw/rtl/fee_pkg.sv]
// fee_pkg: shared types, constants and controller states of the flow error evaluator
// no dependencies
package fee_pkg;

    localparam int unsigned PIXEL_COUNT_LOG2 = 22;
    localparam int unsigned FLOW_FRAC_BITS   = 6;

    localparam int unsigned CNT_W  = 23;
    localparam int unsigned ERR_W  = 34;
    localparam int unsigned PCT_W  = 15;
    localparam int unsigned MEAN_W = 20;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_LIMIT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERCENT_LIMIT  = 8'd1;

    localparam logic [15:0] DISTANCE_LIMIT_RST = 16'd192;
    localparam logic [7:0]  PERCENT_LIMIT_RST  = 8'd5;

    typedef struct packed {
        logic              truth_known;
        logic signed [15:0] truth_dx;
        logic signed [15:0] truth_dy;
        logic              est_known;
        logic signed [15:0] est_dx;
        logic signed [15:0] est_dy;
        logic              frame_end;
    } t_pixel;

    typedef struct packed {
        logic [CNT_W-1:0]  truth_count;
        logic [CNT_W-1:0]  est_count;
        logic [CNT_W-1:0]  overlap_count;
        logic [CNT_W-1:0]  inlier_count;
        logic [ERR_W-1:0]  error_total;
        logic [PCT_W-1:0]  inlier_pct;
        logic [PCT_W-1:0]  coverage_pct;
        logic [MEAN_W-1:0] mean_error;
        logic              no_overlap;
        logic              no_truth;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ, ST_PROD, ST_CMP, ST_SQRT, ST_ACC,
        ST_DIV_INIT, ST_DIV, ST_DIV_NEXT, ST_OUT
    } t_state;

    typedef struct packed {
        logic load;       // capture pixel
        logic sq;         // square differences
        logic prod;       // scaled products
        logic cmp;        // threshold compares
        logic sqrt_start;
        logic sqrt_step;
        logic acc;        // update tallies
        logic div_init;   // start one ratio division
        logic div_step;
        logic div_next;   // store quotient, select next ratio
        logic clear;      // clear tallies after result
    } t_cmd;

    typedef struct packed {
        logic overlap;    // both flags known
        logic frame_end;
        logic sqrt_done;
        logic div_done;
        logic div_last;   // final ratio finished
    } t_status;

endpackage

[hw/rtl/fee_if.sv]
// fee_if: valid/ready channel interfaces for pixels, results and config writes
// depends on fee_pkg
interface fee_pixel_if;
    logic            valid;
    logic            ready;
    fee_pkg::t_pixel data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fee_result_if;
    logic             valid;
    logic             ready;
    fee_pkg::t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fee_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [fee_pkg::CFG_IDX_W-1:0]  index;
    logic [fee_pkg::CFG_DAT_W-1:0]  wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

[hw/rtl/fee_ctrl.sv]
// fee_ctrl: controller state machine sequencing one pixel through the datapath
// depends on fee_pkg
module fee_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  fee_pkg::t_status  i_status,
    output fee_pkg::t_cmd     o_cmd
);
    import fee_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (i_in_valid) n_state = ST_SQ;
            ST_SQ:       n_state = ST_PROD;
            ST_PROD:     n_state = ST_CMP;
            ST_CMP:      n_state = ST_SQRT;
            ST_SQRT:     if (i_status.sqrt_done) n_state = ST_ACC;
            ST_ACC:      n_state = i_status.frame_end ? ST_DIV_INIT : ST_IDLE;
            ST_DIV_INIT: n_state = ST_DIV;
            ST_DIV:      if (i_status.div_done) n_state = ST_DIV_NEXT;
            ST_DIV_NEXT: n_state = i_status.div_last ? ST_OUT : ST_DIV_INIT;
            ST_OUT:      if (i_out_ready) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.load   = i_in_valid;
            end
            ST_SQ:       o_cmd.sq = 1'b1;
            ST_PROD:     o_cmd.prod = 1'b1;
            ST_CMP: begin
                o_cmd.cmp        = 1'b1;
                o_cmd.sqrt_start = 1'b1;
            end
            ST_SQRT:     o_cmd.sqrt_step = 1'b1;
            ST_ACC:      o_cmd.acc = 1'b1;
            ST_DIV_INIT: o_cmd.div_init = 1'b1;
            ST_DIV:      o_cmd.div_step = 1'b1;
            ST_DIV_NEXT: o_cmd.div_next = 1'b1;
            ST_OUT: begin
                o_out_valid = 1'b1;
                o_cmd.clear = i_out_ready;
            end
            default: ;
        endcase
    end
endmodule

[hw/rtl/fee_datapath.sv]
// fee_datapath: squared error, compares, bit-serial square root, tallies, ratio divider
// depends on fee_pkg
module fee_datapath #(
    parameter int unsigned PIXEL_COUNT_LOG2 = fee_pkg::PIXEL_COUNT_LOG2,
    parameter int unsigned FLOW_FRAC_BITS   = fee_pkg::FLOW_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fee_pkg::t_pixel   i_pixel,
    input  logic [15:0]       i_distance_limit,
    input  logic [7:0]        i_percent_limit,
    input  fee_pkg::t_cmd     i_cmd,
    output fee_pkg::t_status  o_status,
    output fee_pkg::t_result  o_result
);
    import fee_pkg::*;

    localparam int unsigned TW = PIXEL_COUNT_LOG2 + 1;        // tally width
    localparam logic [TW-1:0] T_MAX = {TW{1'b1}};
    localparam int unsigned SQW = 35;                          // |d|^2 < 2^35
    localparam int unsigned RTW = 18;                          // root bits
    localparam int unsigned DW  = ERR_W + 8;                   // dividend width
    localparam int unsigned DCW = 6;
    localparam logic [DW-1:0] MEAN_SAT = DW'(1048575);
    localparam logic [DW-1:0] PCT_FULL = DW'(25600);

    t_pixel r_px;
    logic [16:0] r_ddx, r_ddy, r_tx, r_ty;      // magnitudes
    logic [SQW-1:0] r_d2, r_g2;
    logic [31:0] r_dl2;
    logic [15:0] r_pl2;
    logic [SQW+13:0] r_d2k;                      // d2 * 10000
    logic [SQW+15:0] r_pg2;                      // pl^2 * g2
    logic r_inlier;
    // square root
    logic [SQW:0]   r_rem;
    logic [RTW-1:0] r_root;
    logic [4:0]     r_rcnt;
    // tallies
    logic [TW-1:0]    r_truth, r_est, r_ovl, r_inl;
    logic [ERR_W-1:0] r_err;
    // divider
    logic [1:0]     r_sel;
    logic [DW-1:0]  r_num, r_quo;
    logic [TW:0]    r_drem;
    logic [DCW-1:0] r_dcnt;
    logic [PCT_W-1:0]  r_ipct, r_cpct;
    logic [MEAN_W-1:0] r_mean;

    function automatic logic [16:0] mag(input logic signed [16:0] v);
        return v[16] ? 17'(-v) : 17'(v);
    endfunction

    // capture and differences, then squares, scaled products and compares
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px  <= i_pixel;
            r_ddx <= mag(17'(i_pixel.est_dx) - 17'(i_pixel.truth_dx));
            r_ddy <= mag(17'(i_pixel.est_dy) - 17'(i_pixel.truth_dy));
            r_tx  <= mag(17'(i_pixel.truth_dx));
            r_ty  <= mag(17'(i_pixel.truth_dy));
        end
        if (i_cmd.sq) begin
            r_d2  <= SQW'(r_ddx) * SQW'(r_ddx) + SQW'(r_ddy) * SQW'(r_ddy);
            r_g2  <= SQW'(r_tx) * SQW'(r_tx) + SQW'(r_ty) * SQW'(r_ty);
            r_dl2 <= i_distance_limit * i_distance_limit;
            r_pl2 <= i_percent_limit * i_percent_limit;
        end
        if (i_cmd.prod) begin
            r_d2k <= (SQW+14)'(r_d2) * (SQW+14)'(10000);
            r_pg2 <= (SQW+16)'(r_pl2) * (SQW+16)'(r_g2);
        end
        if (i_cmd.cmp) begin
            r_inlier <= (r_d2 < SQW'(r_dl2)) ||
                        ((r_g2 != '0) && ((SQW+16)'(r_d2k) < r_pg2));
        end
    end

    // bit-serial square root, two radicand bits a step
    logic [SQW+1:0] s_sh;
    logic [SQW+1:0] s_try;
    logic [5:0]     s_pos;
    always_comb begin
        s_pos = 6'(2 * (RTW - 1)) - {r_rcnt, 1'b0};
        s_sh  = (SQW+2)'(r_d2 >> s_pos) & (SQW+2)'(3);
        s_sh  = {r_rem[SQW-1:0], 2'b00} | s_sh;
        s_try = (SQW+2)'({r_root, 2'b01});
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_start) begin
            r_rem  <= '0;
            r_root <= '0;
            r_rcnt <= '0;
        end else if (i_cmd.sqrt_step) begin
            if (s_sh >= s_try) begin
                r_rem  <= (SQW+1)'(s_sh - s_try);
                r_root <= {r_root[RTW-2:0], 1'b1};
            end else begin
                r_rem  <= s_sh[SQW:0];
                r_root <= {r_root[RTW-2:0], 1'b0};
            end
            r_rcnt <= r_rcnt + 5'd1;
        end
    end

    // tallies and error total
    logic [ERR_W:0] s_err_sum;
    assign s_err_sum = (ERR_W+1)'(r_err) + (ERR_W+1)'(r_root >> FLOW_FRAC_BITS);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_truth <= '0;
            r_est   <= '0;
            r_ovl   <= '0;
            r_inl   <= '0;
            r_err   <= '0;
        end else if (i_cmd.acc) begin
            if (r_px.truth_known && r_truth != T_MAX) r_truth <= r_truth + 1'b1;
            if (r_px.est_known && r_est != T_MAX) r_est <= r_est + 1'b1;
            if (r_px.truth_known && r_px.est_known) begin
                if (r_ovl != T_MAX) r_ovl <= r_ovl + 1'b1;
                if (r_inlier && r_inl != T_MAX) r_inl <= r_inl + 1'b1;
                r_err <= s_err_sum[ERR_W] ? {ERR_W{1'b1}} : s_err_sum[ERR_W-1:0];
            end
        end
    end

    // restoring divider, one quotient bit a step; ratios in turn
    logic [TW-1:0] s_den;
    logic [TW:0]   s_dtry;
    always_comb begin
        unique case (r_sel)
            2'd1:    s_den = r_truth;
            default: s_den = r_ovl;
        endcase
        s_dtry = {r_drem[TW-1:0], r_num[DW-1]};
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= '0;
        end else if (i_cmd.div_init) begin
            unique case (r_sel)
                2'd0:    r_num <= DW'(r_inl) * PCT_FULL;
                2'd1:    r_num <= DW'(r_ovl) * PCT_FULL;
                default: r_num <= {r_err, 8'd0};
            endcase
            r_quo  <= '0;
            r_drem <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_num <= {r_num[DW-2:0], 1'b0};
            if (s_dtry >= (TW+1)'(s_den)) begin
                r_drem <= s_dtry - (TW+1)'(s_den);
                r_quo  <= {r_quo[DW-2:0], 1'b1};
            end else begin
                r_drem <= s_dtry;
                r_quo  <= {r_quo[DW-2:0], 1'b0};
            end
            r_dcnt <= r_dcnt + 1'b1;
        end else if (i_cmd.div_next) begin
            unique case (r_sel)
                2'd0: r_ipct <= (s_den == '0) ? '0 :
                                (r_quo > PCT_FULL) ? PCT_W'(25600) : r_quo[PCT_W-1:0];
                2'd1: r_cpct <= (s_den == '0) ? '0 :
                                (r_quo > PCT_FULL) ? PCT_W'(25600) : r_quo[PCT_W-1:0];
                default: r_mean <= (s_den == '0) ? '0 :
                                (r_quo > MEAN_SAT) ? {MEAN_W{1'b1}} : r_quo[MEAN_W-1:0];
            endcase
            r_sel <= (r_sel == 2'd2) ? 2'd0 : r_sel + 2'd1;
        end
    end

    // status and result
    always_comb begin
        o_status.overlap   = r_px.truth_known & r_px.est_known;
        o_status.frame_end = r_px.frame_end;
        o_status.sqrt_done = (r_rcnt == 5'(RTW - 1));
        o_status.div_done  = (r_dcnt == DCW'(DW - 1));
        o_status.div_last  = (r_sel == 2'd2);
        o_result.truth_count   = CNT_W'(r_truth);
        o_result.est_count     = CNT_W'(r_est);
        o_result.overlap_count = CNT_W'(r_ovl);
        o_result.inlier_count  = CNT_W'(r_inl);
        o_result.error_total   = r_err;
        o_result.inlier_pct    = r_ipct;
        o_result.coverage_pct  = r_cpct;
        o_result.mean_error    = r_mean;
        o_result.no_overlap    = (r_ovl == '0);
        o_result.no_truth      = (r_truth == '0);
    end
endmodule

[hw/rtl/flow_error_evaluator_unit.sv]
// flow_error_evaluator_unit: top level joining controller, datapath and config registers
// depends on fee_pkg, fee_if, fee_ctrl, fee_datapath
//
// Scores estimated optical flow against ground truth one pixel per transfer. Each
// pixel is worked through before the next pixel is taken: squaring and scaled
// products, then an 18-step bit-serial square root of the squared endpoint error.
// A frame_end pixel adds three 42-step ratio divisions on the shared restoring
// divider, and the result is held until the output transfer completes, after which
// the tallies clear. Config writes are always ready and should be made only while
// the block is idle.
module flow_error_evaluator_unit #(
    parameter int unsigned PIXEL_COUNT_LOG2 = fee_pkg::PIXEL_COUNT_LOG2,
    parameter int unsigned FLOW_FRAC_BITS   = fee_pkg::FLOW_FRAC_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fee_pixel_if.sink     i_pixel,
    fee_result_if.source  o_result,
    fee_cfg_if.sink       i_cfg
);
    import fee_pkg::*;

    logic [15:0] r_distance_limit;
    logic [7:0]  r_percent_limit;
    t_cmd    s_cmd;
    t_status s_status;

    // config registers
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_distance_limit <= DISTANCE_LIMIT_RST;
            r_percent_limit  <= PERCENT_LIMIT_RST;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == REG_DISTANCE_LIMIT) r_distance_limit <= i_cfg.wdata;
            if (i_cfg.index == REG_PERCENT_LIMIT)  r_percent_limit  <= i_cfg.wdata[7:0];
        end
    end

    fee_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pixel.valid),
        .o_in_ready  (i_pixel.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_status    (s_status),
        .o_cmd       (s_cmd)
    );

    fee_datapath #(
        .PIXEL_COUNT_LOG2 (PIXEL_COUNT_LOG2),
        .FLOW_FRAC_BITS   (FLOW_FRAC_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_pixel          (i_pixel.data),
        .i_distance_limit (r_distance_limit),
        .i_percent_limit  (r_percent_limit),
        .i_cmd            (s_cmd),
        .o_status         (s_status),
        .o_result         (o_result.data)
    );
endmodule
